// ----- hdl/lpls_pkg.sv -----
// Shared constants and types for the Lambert point-light shader.
package lpls_pkg;

    localparam int NUM_LIGHTS_DEF = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 53;

    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT0_CP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1_POS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT1_CP  = 3'd5;

    localparam logic [35:0] AMBIENT_RESET = 36'h19A19A19A;

    localparam int SQ_STEPS  = 18;
    localparam int DIV_STEPS = 17;
    localparam int LIGHT_LAT = 3 + SQ_STEPS + DIV_STEPS;

    localparam logic [11:0] CHAN_MAX = 12'hFFF;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec3;

endpackage

// ----- hdl/lpls_in_if.sv -----
// Input channel carrying one surface point per transaction.
interface lpls_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [11:0]        base_red;
    logic [11:0]        base_green;
    logic [11:0]        base_blue;

    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    base_red, base_green, base_blue, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  base_red, base_green, base_blue, output ready);
endinterface

// ----- hdl/lpls_out_if.sv -----
// Output channel carrying one shaded RGB color per transaction.
interface lpls_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_red;
    logic [11:0] out_green;
    logic [11:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/lpls_light.sv -----
// Per-light lane: direction, length by pipelined square root, diffuse by pipelined divide.
module lpls_light (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [47:0]   i_lpos,
    input  lpls_pkg::t_vec3 i_pos,
    input  lpls_pkg::t_vec3 i_norm,
    output logic [lpls_pkg::DIV_STEPS-1:0] o_diffuse
);
    import lpls_pkg::*;

    logic signed [15:0] w_p [3];
    logic signed [15:0] w_n [3];
    logic signed [15:0] w_l [3];
    logic signed [16:0] r_d [3];
    logic signed [15:0] r_n [3];
    logic signed [33:0] w_sq [3];
    logic signed [32:0] w_pr [3];
    logic [33:0]        r_sq [3];
    logic signed [32:0] r_pr [3];
    logic [35:0]        r_len2;
    logic signed [34:0] r_dot;

    logic [35:0]        w_x [SQ_STEPS];
    logic [35:0]        w_r [SQ_STEPS];
    logic signed [34:0] w_sd [SQ_STEPS];
    logic [35:0]        r_x [SQ_STEPS];
    logic [35:0]        r_r [SQ_STEPS];
    logic signed [34:0] r_sd [SQ_STEPS];

    logic [17:0]          w_len;
    logic [33:0]          w_rem [DIV_STEPS];
    logic [17:0]          w_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] w_q [DIV_STEPS];
    logic [33:0]          r_rem [DIV_STEPS];
    logic [17:0]          r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_q [DIV_STEPS];

    assign w_p[0] = i_pos.x;
    assign w_p[1] = i_pos.y;
    assign w_p[2] = i_pos.z;
    assign w_n[0] = i_norm.x;
    assign w_n[1] = i_norm.y;
    assign w_n[2] = i_norm.z;
    assign w_l[0] = i_lpos[15:0];
    assign w_l[1] = i_lpos[31:16];
    assign w_l[2] = i_lpos[47:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= $signed({w_l[k][15], w_l[k]}) - $signed({w_p[k][15], w_p[k]});
                r_n[k] <= w_n[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sq[k] = r_d[k] * r_d[k];
            w_pr[k] = r_n[k] * r_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= unsigned'(w_sq[k]);
                r_pr[k] <= w_pr[k];
            end
            r_len2 <= 36'(r_sq[0]) + 36'(r_sq[1]) + 36'(r_sq[2]);
            r_dot  <= 35'(r_pr[0]) + 35'(r_pr[1]) + 35'(r_pr[2]);
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        logic [35:0] w_bit;
        logic [35:0] w_t;
        if (s == 0) begin : g_first
            assign w_x[s]  = r_len2;
            assign w_r[s]  = '0;
            assign w_sd[s] = r_dot;
        end else begin : g_next
            assign w_x[s]  = r_x[s-1];
            assign w_r[s]  = r_r[s-1];
            assign w_sd[s] = r_sd[s-1];
        end
        assign w_bit = 36'(1) << (34 - 2 * s);
        assign w_t   = w_r[s] + w_bit;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[s] <= w_sd[s];
                if (w_x[s] >= w_t) begin
                    r_x[s] <= w_x[s] - w_t;
                    r_r[s] <= (w_r[s] >> 1) + w_bit;
                end else begin
                    r_x[s] <= w_x[s];
                    r_r[s] <= w_r[s] >> 1;
                end
            end
        end
    end

    assign w_len = r_r[SQ_STEPS-1][17:0];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [33:0] w_ds;
        if (j == 0) begin : g_first
            assign w_rem[j] = (r_sd[SQ_STEPS-1] > 35'sd0 && w_len != '0)
                              ? r_sd[SQ_STEPS-1][33:0] : '0;
            assign w_den[j] = (w_len == '0) ? 18'd1 : w_len;
            assign w_q[j]   = '0;
        end else begin : g_next
            assign w_rem[j] = r_rem[j-1];
            assign w_den[j] = r_den[j-1];
            assign w_q[j]   = r_q[j-1];
        end
        assign w_ds = 34'(w_den[j]) << (DIV_STEPS - 1 - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= w_den[j];
                if (w_rem[j] >= w_ds) begin
                    r_rem[j] <= w_rem[j] - w_ds;
                    r_q[j]   <= w_q[j] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
                end else begin
                    r_rem[j] <= w_rem[j];
                    r_q[j]   <= w_q[j];
                end
            end
        end
    end

    assign o_diffuse = r_q[DIV_STEPS-1];

endmodule

// ----- hdl/lambert_point_light_shader.sv -----
// Lambert point-light shader top level: config registers, lanes, color mix and output.
// Pipeline: 3 setup stages, 18 square-root steps, 17 divide steps and
// 4 color multiply/accumulate stages between input transaction and result valid.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and restores config defaults.
module lambert_point_light_shader #(
    parameter int NUM_LIGHTS = lpls_pkg::NUM_LIGHTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpls_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpls_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lpls_in_if.sink                           i_in,
    lpls_out_if.source                        o_out
);
    import lpls_pkg::*;

    localparam int TOT = LIGHT_LAT + 4;

    logic [35:0] r_ambient;
    logic [1:0]  r_count;
    logic [47:0] r_lpos [NUM_LIGHTS];
    logic [52:0] r_lcp  [NUM_LIGHTS];

    logic           w_en;
    logic [TOT-1:0] r_vld;
    logic [35:0]    r_base [LIGHT_LAT];
    t_vec3          w_pos;
    t_vec3          w_norm;
    logic [1:0]     w_cnt;
    logic [35:0]    w_base;

    logic [DIV_STEPS-1:0] w_diff [NUM_LIGHTS];
    logic           w_act  [NUM_LIGHTS];
    logic [23:0]    r_cb   [NUM_LIGHTS][3];
    logic [32:0]    r_id   [NUM_LIGHTS];
    logic [23:0]    r_amb  [3];
    logic [56:0]    r_term [NUM_LIGHTS][3];
    logic [23:0]    r_amb2 [3];
    logic [58:0]    w_acc  [3];
    logic [58:0]    r_acc  [3];
    logic [11:0]    r_out  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient <= AMBIENT_RESET;
            r_count   <= '0;
            for (int i = 0; i < NUM_LIGHTS; i++) begin
                r_lpos[i] <= '0;
                r_lcp[i]  <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_AMBIENT) begin
                r_ambient <= i_cfg_data[35:0];
            end
            if (i_cfg_idx == CFG_COUNT) begin
                r_count <= i_cfg_data[1:0];
            end
            for (int i = 0; i < NUM_LIGHTS; i++) begin
                if (i_cfg_idx == CFG_LIGHT0_POS + CFG_IDX_W'(2 * i)) begin
                    r_lpos[i] <= i_cfg_data[47:0];
                end
                if (i_cfg_idx == CFG_LIGHT0_CP + CFG_IDX_W'(2 * i)) begin
                    r_lcp[i] <= i_cfg_data[52:0];
                end
            end
        end
    end

    assign w_en       = !r_vld[TOT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base[0] <= {i_in.base_blue, i_in.base_green, i_in.base_red};
            for (int j = 1; j < LIGHT_LAT; j++) begin
                r_base[j] <= r_base[j-1];
            end
        end
    end

    assign w_pos  = '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z};
    assign w_norm = '{x: i_in.norm_x, y: i_in.norm_y, z: i_in.norm_z};
    assign w_cnt  = (r_count > 2'(NUM_LIGHTS)) ? 2'(NUM_LIGHTS) : r_count;
    assign w_base = r_base[LIGHT_LAT-1];

    for (genvar i = 0; i < NUM_LIGHTS; i++) begin : g_lane
        lpls_light u_light (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_lpos    (r_lpos[i]),
            .i_pos     (w_pos),
            .i_norm    (w_norm),
            .o_diffuse (w_diff[i])
        );

        assign w_act[i] = r_lcp[i][52] && (2'(i) < w_cnt);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_id[i] <= w_act[i] ? r_lcp[i][51:36] * w_diff[i] : '0;
                for (int k = 0; k < 3; k++) begin
                    r_cb[i][k]   <= r_lcp[i][12*k +: 12] * w_base[12*k +: 12];
                    r_term[i][k] <= 57'(r_cb[i][k]) * 57'(r_id[i]);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = {9'd0, r_amb2[k], 26'd0};
            for (int i = 0; i < NUM_LIGHTS; i++) begin
                w_acc[k] = w_acc[k] + 59'(r_term[i][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_amb[k]  <= r_ambient[12*k +: 12] * w_base[12*k +: 12];
                r_amb2[k] <= r_amb[k];
                r_acc[k]  <= w_acc[k];
                r_out[k]  <= (|r_acc[k][58:50]) ? CHAN_MAX : r_acc[k][49:38];
            end
        end
    end

    assign o_out.valid     = r_vld[TOT-1];
    assign o_out.out_red   = r_out[0];
    assign o_out.out_green = r_out[1];
    assign o_out.out_blue  = r_out[2];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid line moved during stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_lane0_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && !w_act[0] |=> r_id[0] == '0)
        else $error("inactive light contributed");

endmodule

// ----- dv/lpls_tb_if.sv -----
// Testbench configuration write bus driven into the shader.
`timescale 1ns / 100ps
interface lpls_tb_cfg_if;
    import lpls_pkg::*;
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
endinterface

// ----- dv/tb_top.sv -----
// Self-checking testbench for the Lambert point-light shader: random and directed fragments.
`timescale 1ns / 100ps
module tb_top;
    import lpls_pkg::*;

    typedef struct packed {
        logic [15:0] px, py, pz, nx, ny, nz;
        logic [11:0] br, bg, bb;
    } t_frag;
    typedef struct packed {
        logic [11:0] r, g, b;
    } t_rgb;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;
    localparam int LATENCY = LIGHT_LAT + 4;
    localparam int STALL_LIMIT = 20000;

    logic i_clk, i_rst_n;

    lpls_tb_cfg_if cfg();
    lpls_in_if in_ch();
    lpls_out_if out_ch();

    lambert_point_light_shader DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg.we), .i_cfg_idx(cfg.idx),
        .i_cfg_data(cfg.data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    logic [35:0] ambient;
    logic [1:0]  lights_used;
    logic [47:0] lpos [2];
    logic [52:0] lcp [2];

    t_frag pending_frags[$];
    t_rgb  expected_colors[$];
    int src_idle_pct, sink_stall_pct, hold_off;
    int mismatches, accepted_in, accepted_out, quiet_cycles;
    bit in_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_rgb shade(t_frag f);
        longint p[3], n[3], d, dotp;
        logic [63:0] base[3], acc[3], len2, len, diffuse, inten, v;
        logic [63:0] cnt;
        t_rgb res;
        p[0] = longint'($signed(f.px)); p[1] = longint'($signed(f.py));
        p[2] = longint'($signed(f.pz));
        n[0] = longint'($signed(f.nx)); n[1] = longint'($signed(f.ny));
        n[2] = longint'($signed(f.nz));
        base[0] = f.br; base[1] = f.bg; base[2] = f.bb;
        for (int k = 0; k < 3; k++) acc[k] = (64'(ambient[12*k +: 12]) * base[k]) << 26;
        cnt = (lights_used > NUM_LIGHTS_DEF) ? NUM_LIGHTS_DEF : lights_used;
        for (int i = 0; i < cnt; i++) begin
            if (!lcp[i][52]) continue;
            len2 = 0;
            dotp = 0;
            for (int k = 0; k < 3; k++) begin
                d = longint'($signed(lpos[i][16*k +: 16])) - p[k];
                len2 += 64'(d * d);
                dotp += n[k] * d;
            end
            len = int_sqrt(len2);
            if (len == 0 || dotp <= 0) continue;
            diffuse = 64'(dotp) / len;
            inten = lcp[i][51:36];
            for (int k = 0; k < 3; k++)
                acc[k] += 64'(lcp[i][12*k +: 12]) * inten * diffuse * base[k];
        end
        v = acc[0] >> 38; res.r = (v > 4095) ? CHAN_MAX : v[11:0];
        v = acc[1] >> 38; res.g = (v > 4095) ? CHAN_MAX : v[11:0];
        v = acc[2] >> 38; res.b = (v > 4095) ? CHAN_MAX : v[11:0];
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg.we <= 1'b1;
        cfg.idx <= idx;
        cfg.data <= data;
        case (idx)
            CFG_AMBIENT:    ambient = data[35:0];
            CFG_COUNT:      lights_used = data[1:0];
            CFG_LIGHT0_POS: lpos[0] = data[47:0];
            CFG_LIGHT0_CP:  lcp[0] = data[52:0];
            CFG_LIGHT1_POS: lpos[1] = data[47:0];
            CFG_LIGHT1_CP:  lcp[1] = data[52:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg.we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord(bit near);
        return near ? 16'($signed($urandom_range(0, 4096)) - 2048) : 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_norm();
        case ($urandom_range(0, 3))
            0: return 16'(16384);
            1: return 16'(-16384);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_frag rand_frag();
        t_frag f;
        bit near;
        near = $urandom_range(0, 3) != 0;
        f.px = rand_coord(near); f.py = rand_coord(near); f.pz = rand_coord(near);
        f.nx = rand_norm(); f.ny = rand_norm(); f.nz = rand_norm();
        f.br = 12'($urandom); f.bg = 12'($urandom); f.bb = 12'($urandom);
        return f;
    endfunction

    function automatic logic [52:0] rand_cp(bit en);
        logic [52:0] cp;
        cp = {21'($urandom), 32'($urandom)};
        cp[52] = en;
        return cp;
    endfunction

    task automatic drain();
        while (pending_frags.size() != 0 || expected_colors.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic random_config();
        write_reg(CFG_AMBIENT, 53'({4'($urandom), 32'($urandom)}));
        write_reg(CFG_COUNT, 53'($urandom_range(0, 3)));
        write_reg(CFG_LIGHT0_POS, {5'($urandom), rand_coord(1), rand_coord(1), rand_coord(1)});
        write_reg(CFG_LIGHT0_CP, rand_cp($urandom_range(0, 4) != 0));
        write_reg(CFG_LIGHT1_POS, {5'($urandom), rand_coord(1), rand_coord(1), rand_coord(1)});
        write_reg(CFG_LIGHT1_CP, rand_cp($urandom_range(0, 4) != 0));
        write_reg(CFG_UNUSED_IDX, 53'($urandom));
    endtask

    task automatic run_phase(int count, int idle, int stall);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        for (int i = 0; i < count; i++) pending_frags.push_back(rand_frag());
        drain();
    endtask

    // driver
    t_frag cur;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_frags.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                cur = pending_frags[0];
                in_ch.valid <= 1'b1;
                {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} <= {cur.px, cur.py, cur.pz};
                {in_ch.norm_x, in_ch.norm_y, in_ch.norm_z} <= {cur.nx, cur.ny, cur.nz};
                {in_ch.base_red, in_ch.base_green, in_ch.base_blue} <= {cur.br, cur.bg, cur.bb};
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // sink backpressure
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= $urandom_range(0, 99) >= sink_stall_pct;
        end
    end

    // monitor
    t_rgb got, exp_c;
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_colors.push_back(shade(pending_frags.pop_front()));
                accepted_in <= accepted_in + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                accepted_out <= accepted_out + 1;
                got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue};
                if (expected_colors.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %p", got);
                end else begin
                    exp_c = expected_colors.pop_front();
                    if (got !== exp_c) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p got %p", exp_c, got);
                    end
                end
            end
            if (quiet_cycles > STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_frag f;
        i_rst_n = 1'b0; cfg.we = 1'b0; cfg.idx = '0; cfg.data = '0;
        in_ch.valid = 1'b0; out_ch.ready = 1'b0; in_taken = 1'b0;
        {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} = '0;
        {in_ch.norm_x, in_ch.norm_y, in_ch.norm_z} = '0;
        {in_ch.base_red, in_ch.base_green, in_ch.base_blue} = '0;
        src_idle_pct = 0; sink_stall_pct = 0; hold_off = 0;
        mismatches = 0; accepted_in = 0; accepted_out = 0; quiet_cycles = 0;
        ambient = AMBIENT_RESET; lights_used = 0;
        lpos[0] = 0; lpos[1] = 0; lcp[0] = 0; lcp[1] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: ambient only, extremes of base color
        f = '{16'h7FFF, 16'h8000, 0, 16'(16384), 16'(-16384), 0, 12'hFFF, 0, 12'hFFF};
        pending_frags.push_back(f);
        f = '{16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 16'(16384), 12'hFFF, 12'hFFF, 12'hFFF};
        pending_frags.push_back(f);
        drain();

        // directed: lights at origin / above, bright, both enabled
        write_reg(CFG_AMBIENT, 53'hF_FFFF_FFFF);
        write_reg(CFG_COUNT, 53'd3);
        write_reg(CFG_LIGHT0_POS, {16'h0400, 16'h0, 16'h0});
        write_reg(CFG_LIGHT0_CP, {1'b1, 16'hFFFF, 36'hF_FFFF_FFFF});
        write_reg(CFG_LIGHT1_POS, 48'h0);
        write_reg(CFG_LIGHT1_CP, {1'b1, 16'h1000, 36'h800_800_800});
        // zero-length direction for light 1, front-facing light 0
        pending_frags.push_back('{0, 0, 0, 0, 0, 16'(16384), 12'h800, 12'h001, 12'hFFF});
        // back-facing
        pending_frags.push_back('{0, 0, 0, 0, 0, 16'(-16384), 12'hFFF, 12'hFFF, 12'hFFF});
        // non-unit normal, far position
        pending_frags.push_back('{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                  12'h123, 12'h456, 12'h789});
        pending_frags.push_back('{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                  12'h0, 12'h0, 12'h0});
        // oversized normal next to light 0: diffuse above 16 bits
        pending_frags.push_back('{16'hFFFF, 16'hFFFF, 16'h03FF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  12'h001, 12'h001, 12'h001});
        for (int i = 0; i < 8; i++) pending_frags.push_back(rand_frag());
        drain();
        write_reg(CFG_LIGHT0_CP, {1'b0, 16'hFFFF, 36'hF_FFFF_FFFF});
        write_reg(CFG_AMBIENT, 53'h0);
        for (int i = 0; i < 6; i++) pending_frags.push_back(rand_frag());
        drain();

        random_config(); run_phase(200, 0, 0);
        random_config(); run_phase(200, 62, 0);
        random_config(); run_phase(200, 0, 62);
        random_config(); run_phase(200, 27, 27);
        // long receiver hold-off while the sender keeps offering
        random_config();
        @(negedge i_clk);
        hold_off = 300;
        run_phase(230, 0, 0);
        write_reg(CFG_COUNT, 53'd0);
        run_phase(10, 0, 0);

        $display("Ran %0d fragments, %0d colors checked, over several light setups",
                 accepted_in, accepted_out);
        $display("and idle, stall and long back-pressure phases; %0d mismatches.", mismatches);
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/lpls_pkg.sv
hdl/lpls_in_if.sv
hdl/lpls_out_if.sv
hdl/lpls_light.sv
hdl/lambert_point_light_shader.sv
dv/lpls_tb_if.sv
dv/tb_top.sv
